### design/rsch_pkg.sv
// Shared types, widths and codes for the ray/sphere closest-hit core.
`default_nettype none
package rsch_pkg;

  localparam int MaxSpheres = 32;
  localparam int IdxW       = $clog2(MaxSpheres);
  localparam int CountW     = 6;
  localparam int DataW      = 32;
  localparam int RadW       = 31;
  localparam int EW         = DataW + 1;
  localparam int MW         = 68;
  localparam int PW         = 2 * MW;
  localparam int AW         = 64;
  localparam int FracW      = 16;
  localparam int NW         = 86;
  localparam int DivCntW    = $clog2(NW);

  localparam logic signed [DataW-1:0] TInf = {1'b0, {(DataW-1){1'b1}}};

  typedef struct packed {
    logic                    kind;
    logic [IdxW-1:0]         slot;
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] pos_z;
    logic signed [DataW-1:0] dir_x;
    logic signed [DataW-1:0] dir_y;
    logic signed [DataW-1:0] dir_z;
    logic [RadW-1:0]         radius;
    logic signed [DataW-1:0] t_min;
    logic signed [DataW-1:0] t_max;
  } in_word_t;

  typedef struct packed {
    logic                    hit;
    logic [IdxW-1:0]         sphere_index;
    logic signed [DataW-1:0] hit_t;
  } out_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] cx;
    logic signed [DataW-1:0] cy;
    logic signed [DataW-1:0] cz;
    logic [RadW-1:0]         r;
  } sphere_t;

  typedef struct packed {
    logic busy;
    logic shift;
    logic done;
  } ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_MUL, ST_POST, ST_SPH, ST_SQRT,
    ST_ROOT, ST_DIV, ST_PICK, ST_NEXT, ST_DONE
  } solv_state_e;

  typedef enum logic [3:0] {
    JOB_DXX, JOB_DYY, JOB_DZZ,
    JOB_EDX, JOB_EDY, JOB_EDZ,
    JOB_EXX, JOB_EYY, JOB_EZZ, JOB_RR,
    JOB_HH, JOB_AC
  } job_e;

endpackage
`default_nettype wire

### design/rsch_cell.sv
// One sphere table cell of the rotating chain.
`default_nettype none
module rsch_cell
  import rsch_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    shift_i,
  input  wire logic    wr_i,
  input  wire sphere_t wr_ent_i,
  input  wire sphere_t nb_i,
  output sphere_t      ent_o
);

  sphere_t ent_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ent_q <= wr_ent_i;
    end else if (shift_i) begin
      ent_q <= nb_i;
    end
  end

  assign ent_o = ent_q;

endmodule
`default_nettype wire

### design/rsch_solver.sv
// Sequential quadratic solver: bit-serial multiply, square root and divide.
`default_nettype none
module rsch_solver
  import rsch_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire in_word_t          ray_i,
  input  wire logic [CountW-1:0] count_i,
  input  wire sphere_t           head_i,
  input  wire logic              take_i,
  output ctl_t                   ctl_o,
  output out_word_t              res_o
);

  solv_state_e state_q, state_d;
  job_e        job_q, job_d;
  logic [IdxW-1:0]    i_q, i_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               root_q, root_d;
  logic               found_q, found_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic signed [DataW-1:0] best_q, best_d;

  in_word_t              ray_q, ray_d;
  logic [AW-1:0]         a_q, a_d;
  logic signed [MW-1:0]  h_q, h_d, c_q, c_d;
  logic signed [EW-1:0]  ex_q, ex_d, ey_q, ey_d, ez_q, ez_d;
  logic signed [PW-1:0]  acc_q, acc_d, mx_q, mx_d;
  logic [MW-1:0]         my_q, my_d;
  logic [PW-1:0]         sres_q, sres_d, bit_q, bit_d;
  logic [NW-1:0]         m_q, m_d, quo_q, quo_d;
  logic [AW-1:0]         rem_q, rem_d;
  logic                  nneg_q, nneg_d;

  logic signed [MW-1:0] opx, opy;
  logic                 opneg, opclr;
  logic                 ysgn;
  logic signed [PW-1:0] xw;
  logic [PW-1:0]        trial;
  logic                 sq_ge;
  logic [AW:0]          r2, rdiff;
  logic                 dv_ge;
  logic [NW-1:0]        hn, sx, sumv, numv;
  logic signed [NW-1:0] tneg, t_s, tmin_s, tmax_s, best_s;

  always_comb begin
    opx   = '0;
    opy   = '0;
    opneg = 1'b0;
    opclr = 1'b0;
    case (job_q)
      JOB_DXX: begin
        opx   = MW'(ray_q.dir_x);
        opy   = MW'(ray_q.dir_x);
        opclr = 1'b1;
      end
      JOB_DYY: begin
        opx = MW'(ray_q.dir_y);
        opy = MW'(ray_q.dir_y);
      end
      JOB_DZZ: begin
        opx = MW'(ray_q.dir_z);
        opy = MW'(ray_q.dir_z);
      end
      JOB_EDX: begin
        opx   = MW'(ex_q);
        opy   = MW'(ray_q.dir_x);
        opclr = 1'b1;
      end
      JOB_EDY: begin
        opx = MW'(ey_q);
        opy = MW'(ray_q.dir_y);
      end
      JOB_EDZ: begin
        opx = MW'(ez_q);
        opy = MW'(ray_q.dir_z);
      end
      JOB_EXX: begin
        opx   = MW'(ex_q);
        opy   = MW'(ex_q);
        opclr = 1'b1;
      end
      JOB_EYY: begin
        opx = MW'(ey_q);
        opy = MW'(ey_q);
      end
      JOB_EZZ: begin
        opx = MW'(ez_q);
        opy = MW'(ez_q);
      end
      JOB_RR: begin
        opx   = MW'(head_i.r);
        opy   = MW'(head_i.r);
        opneg = 1'b1;
      end
      JOB_HH: begin
        opx   = h_q;
        opy   = h_q;
        opclr = 1'b1;
      end
      JOB_AC: begin
        opx   = MW'(a_q);
        opy   = c_q;
        opneg = 1'b1;
      end
      default: begin
        opx = '0;
      end
    endcase
  end

  always_comb begin
    ysgn   = opy[MW-1];
    xw     = PW'(opx);
    trial  = sres_q + bit_q;
    sq_ge  = $unsigned(acc_q) >= trial;
    r2     = {rem_q, m_q[NW-1]};
    rdiff  = r2 - {1'b0, a_q};
    dv_ge  = r2 >= {1'b0, a_q};
    hn     = -(NW'(h_q));
    sx     = NW'(sres_q[MW-1:0]);
    sumv   = root_q ? (hn - sx) : (hn + sx);
    numv   = sumv << FracW;
    tneg   = -$signed(quo_q);
    t_s    = nneg_q ? (tneg - NW'(rem_q != '0)) : $signed(quo_q);
    tmin_s = NW'(ray_q.t_min);
    tmax_s = NW'(ray_q.t_max);
    best_s = NW'(best_q);
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    i_d     = i_q;
    cnt_d   = cnt_q;
    root_d  = root_q;
    found_d = found_q;
    idx_d   = idx_q;
    best_d  = best_q;
    ray_d   = ray_q;
    a_d     = a_q;
    h_d     = h_q;
    c_d     = c_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    ez_d    = ez_q;
    acc_d   = acc_q;
    mx_d    = mx_q;
    my_d    = my_q;
    sres_d  = sres_q;
    bit_d   = bit_q;
    m_d     = m_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    nneg_d  = nneg_q;
    ctl_o   = '0;
    ctl_o.busy = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ray_d   = ray_i;
          job_d   = JOB_DXX;
          i_d     = '0;
          best_d  = TInf;
          found_d = 1'b0;
          idx_d   = '0;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        acc_d   = opclr ? '0 : acc_q;
        mx_d    = (ysgn ^ opneg) ? -xw : xw;
        my_d    = ysgn ? -opy : opy;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (my_q[0]) begin
          acc_d = acc_q + mx_q;
        end
        mx_d = mx_q <<< 1;
        my_d = my_q >> 1;
        if (my_q[MW-1:1] == '0) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        case (job_q)
          JOB_DZZ: begin
            a_d     = acc_q[AW-1:0];
            state_d = ST_SPH;
          end
          JOB_EDZ: begin
            h_d     = acc_q[MW-1:0];
            job_d   = job_e'(job_q + 4'd1);
            state_d = ST_SETUP;
          end
          JOB_RR: begin
            c_d     = acc_q[MW-1:0];
            job_d   = job_e'(job_q + 4'd1);
            state_d = ST_SETUP;
          end
          JOB_AC: begin
            if (acc_q[PW-1]) begin
              state_d = ST_NEXT;
            end else begin
              sres_d  = '0;
              bit_d   = PW'(1) << (PW - 2);
              state_d = ST_SQRT;
            end
          end
          default: begin
            job_d   = job_e'(job_q + 4'd1);
            state_d = ST_SETUP;
          end
        endcase
      end
      ST_SPH: begin
        if (a_q == '0 || CountW'(i_q) >= count_i) begin
          state_d = ST_NEXT;
        end else begin
          ex_d    = EW'(ray_q.pos_x) - EW'(head_i.cx);
          ey_d    = EW'(ray_q.pos_y) - EW'(head_i.cy);
          ez_d    = EW'(ray_q.pos_z) - EW'(head_i.cz);
          job_d   = JOB_EDX;
          state_d = ST_SETUP;
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          acc_d  = acc_q - $signed(trial);
          sres_d = (sres_q >> 1) + bit_q;
        end else begin
          sres_d = sres_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          root_d  = 1'b0;
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        nneg_d  = numv[NW-1];
        m_d     = numv[NW-1] ? -numv : numv;
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = dv_ge ? rdiff[AW-1:0] : r2[AW-1:0];
        quo_d = {quo_q[NW-2:0], dv_ge};
        m_d   = m_q << 1;
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(NW - 1)) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (tmin_s <= t_s && t_s <= tmax_s && t_s < best_s) begin
          best_d  = t_s[DataW-1:0];
          idx_d   = i_q;
          found_d = 1'b1;
        end
        if (!root_q) begin
          root_d  = 1'b1;
          state_d = ST_ROOT;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        ctl_o.shift = 1'b1;
        if (i_q == IdxW'(MaxSpheres - 1)) begin
          state_d = ST_DONE;
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = ST_SPH;
        end
      end
      ST_DONE: begin
        ctl_o.done = 1'b1;
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_DXX;
      i_q     <= '0;
      cnt_q   <= '0;
      root_q  <= 1'b0;
      found_q <= 1'b0;
      idx_q   <= '0;
      best_q  <= TInf;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      root_q  <= root_d;
      found_q <= found_d;
      idx_q   <= idx_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ray_q  <= ray_d;
    a_q    <= a_d;
    h_q    <= h_d;
    c_q    <= c_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    ez_q   <= ez_d;
    acc_q  <= acc_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    sres_q <= sres_d;
    bit_q  <= bit_d;
    m_q    <= m_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    nneg_q <= nneg_d;
  end

  assign res_o.hit          = found_q;
  assign res_o.sphere_index = found_q ? idx_q : '0;
  assign res_o.hit_t        = best_q;

endmodule
`default_nettype wire

### design/ray_sphere_closest_hit_core.sv
// Top level: sphere chain, solver, output register and count register.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (in_word_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (out_word_t)
//   cfg      input      cfg_we_i                   cfg_data_i (sphere_count)
//
// A load word is written straight into its cell. A ray word first forms d.d, then tests
// each sphere in turn, steps past each untested entry of the chain of 32 and hands over the
// result; the shared bit-serial multiplier, square root and divider do the work and end
// early on short operands or a negative discriminant. The chain rotates once per entry.
// Reset clears control and the count; table contents are kept undefined.
// A waiting result does not block the next word; a second result holds the input stalled.
`default_nettype none
module ray_sphere_closest_hit_core
  import rsch_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_word_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_word_t              out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_data_i
);

  sphere_t           ent [MaxSpheres];
  sphere_t           wr_ent;
  ctl_t              ctl;
  out_word_t         res;
  logic              in_acc, free;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q;

  assign in_stall_o = ctl.busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign free       = !out_valid_q || !out_stall_i;

  assign wr_ent.cx = in_data_i.pos_x;
  assign wr_ent.cy = in_data_i.pos_y;
  assign wr_ent.cz = in_data_i.pos_z;
  assign wr_ent.r  = in_data_i.radius;

  for (genvar k = 0; k < MaxSpheres; k++) begin : g_cell
    rsch_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (ctl.shift),
      .wr_i     (in_acc && !in_data_i.kind && in_data_i.slot == IdxW'(k)),
      .wr_ent_i (wr_ent),
      .nb_i     (ent[(k + 1) % MaxSpheres]),
      .ent_o    (ent[k])
    );
  end

  rsch_solver u_solver (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && in_data_i.kind),
    .ray_i   (in_data_i),
    .count_i (count_q),
    .head_i  (ent[0]),
    .take_i  (free),
    .ctl_o   (ctl),
    .res_o   (res)
  );

  always_comb begin
    count_d     = cfg_we_i ? cfg_data_i : count_q;
    out_valid_d = out_valid_q;
    if (ctl.done && free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.done && free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_shift_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.shift |-> ctl.busy)
    else $error("chain shifted while solver idle");

  a_ray_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.kind) |=> ctl.busy)
    else $error("accepted ray did not start solver");

  a_miss_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      (out_data_o.hit_t == TInf && out_data_o.sphere_index == '0))
    else $error("miss word carries index or t");
`endif

endmodule
`default_nettype wire
